>>> rtl/core/recursive_mutex_priority_handoff_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recursive mutex block
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_PRIORITY_HANDOFF_DEFINES_SVH
`define RECURSIVE_MUTEX_PRIORITY_HANDOFF_DEFINES_SVH

// Plain clocked property, switched off while reset is asserted.
`define RMPH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define RMPH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `RMPH_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RMPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `RMPH_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

>>> rtl/core/rmph_pkg.sv
// ----------------------------------------------------------------------------
// rmph_pkg
// Types, constants and helpers shared by the recursive mutex block.
// ----------------------------------------------------------------------------
package rmph_pkg;

  // Sizing of the lock state.
  localparam int MaxWaiters     = 16;
  localparam int MaxNesting     = 255;
  localparam int PriorityLevels = 32;

  localparam int TidW   = 8;
  localparam int PriW   = 5;
  localparam int DepthW = 8;
  localparam int IdxW   = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1;
  localparam int CntW   = $clog2(MaxWaiters + 1);

  // Configuration port.
  localparam int AddrW = 3;
  localparam int DataW = 32;

  typedef enum logic [0:0] {
    RegRecursiveMode = 1'b0
  } reg_idx_e;

  typedef enum logic [0:0] {
    OpAcquire = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatOverflow  = 2'd1,
    StatNotHolder = 2'd2,
    StatFull      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StShift,
    StDrain
  } state_e;

  // One request beat.
  typedef struct packed {
    op_e             operation;
    logic [TidW-1:0] thread_id;
    logic [PriW-1:0] req_prio;
  } rmph_in_t;

  // One result beat.
  typedef struct packed {
    status_e         status;
    logic            granted;
    logic            waiting;
    logic            handoff_valid;
    logic [TidW-1:0] new_holder;
  } rmph_out_t;

  // One waiter table entry.
  typedef struct packed {
    logic [TidW-1:0] id;
    logic [PriW-1:0] pri;
  } waiter_t;

  // Access request towards the waiter table.
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    waiter_t         wdata;
  } ram_req_t;

  // Clamp a priority to the highest supported level.
  function automatic logic [PriW-1:0] sat_pri(input logic [PriW-1:0] p);
    logic [PriW-1:0] r;
    r = p;
    if (int'(p) > PriorityLevels - 1) begin
      r = PriW'(PriorityLevels - 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/recursive_mutex_priority_handoff.sv
// ----------------------------------------------------------------------------
// recursive_mutex_priority_handoff
// Hardware recursive mutex with a priority-ordered waiter table.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and returns exactly one result
// beat for it. An acquire, or a release that only lowers the nesting depth or
// frees the lock, is accepted in the idle state and finished in the execute state.
// A release that hands the lock on reads the waiter table once per waiting
// thread to find the highest priority, then moves every younger entry down by
// one slot; the table has a single read port, so this goes one entry at a time.
// A finished result sits in the output register; while it is stalled the next
// request is still taken and worked on, and only its own result waits. The
// mode register may be written only while no request is in progress.
// ----------------------------------------------------------------------------
module recursive_mutex_priority_handoff (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rmph_pkg::rmph_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rmph_pkg::rmph_out_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmph_pkg::AddrW-1:0] paddr,
  input  logic [rmph_pkg::DataW-1:0] pwdata,
  output logic [rmph_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  logic               recursive_mode;
  rmph_pkg::ram_req_t ram_req;
  rmph_pkg::waiter_t  ram_rdata;

  // Configuration registers.
  rmph_cfg_regs u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .recursive_mode_o (recursive_mode)
  );

  // Waiter table.
  rmph_waiter_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Lock sequencer.
  rmph_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .recursive_mode_i (recursive_mode),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata)
  );

endmodule

>>> rtl/core/rmph_waiter_ram.sv
// ----------------------------------------------------------------------------
// rmph_waiter_ram
// Single-read, single-write waiter table with a registered read port.
// ----------------------------------------------------------------------------
module rmph_waiter_ram (
  input  logic               clk_i,
  input  rmph_pkg::ram_req_t req_i,
  output rmph_pkg::waiter_t  rdata_o
);

  rmph_pkg::waiter_t mem [rmph_pkg::MaxWaiters];
  rmph_pkg::waiter_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rmph_cfg_regs.sv
// ----------------------------------------------------------------------------
// rmph_cfg_regs
// APB-style register slave holding the lock mode setting.
// ----------------------------------------------------------------------------
module rmph_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmph_pkg::AddrW-1:0] paddr,
  input  logic [rmph_pkg::DataW-1:0] pwdata,
  output logic [rmph_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output logic                       recursive_mode_o
);

  logic                 mode_q, mode_d;
  rmph_pkg::reg_idx_e   reg_idx;
  logic                 in_range;
  logic                 wr_en;

  // Register decode: word index sits above the byte offset.
  assign reg_idx  = rmph_pkg::reg_idx_e'(paddr[2]);
  assign in_range = (reg_idx == rmph_pkg::RegRecursiveMode);
  assign wr_en    = psel && penable && pwrite && in_range;
  assign pready   = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      rmph_pkg::RegRecursiveMode: prdata = {{(rmph_pkg::DataW-1){1'b0}}, mode_q};
      default:                    prdata = '0;
    endcase
  end

  assign recursive_mode_o = mode_q;

endmodule

>>> rtl/core/rmph_ctrl.sv
// ----------------------------------------------------------------------------
// rmph_ctrl
// Lock sequencer: holder state, request decode, waiter scan and compaction.
// ----------------------------------------------------------------------------
module rmph_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                recursive_mode_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmph_pkg::rmph_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmph_pkg::rmph_out_t out_data_o,
  output rmph_pkg::ram_req_t  ram_req_o,
  input  rmph_pkg::waiter_t   ram_rdata_i
);

  localparam int IdxW   = rmph_pkg::IdxW;
  localparam int CntW   = rmph_pkg::CntW;
  localparam int TidW   = rmph_pkg::TidW;
  localparam int PriW   = rmph_pkg::PriW;
  localparam int DepthW = rmph_pkg::DepthW;

  rmph_pkg::state_e    state_q, state_d;
  rmph_pkg::rmph_in_t  item_q, item_d;
  logic                holder_valid_q, holder_valid_d;
  logic [TidW-1:0]     holder_q, holder_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [PriW-1:0]     best_pri_q, best_pri_d;
  logic [TidW-1:0]     best_id_q, best_id_d;
  rmph_pkg::rmph_out_t res_q, res_d;
  rmph_pkg::rmph_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                is_holder;
  logic [DepthW-1:0]   limit;
  logic                out_free;
  logic                exec_scan;
  logic                take_cur;
  logic                last_rd;
  logic [CntW-1:0]     after_best;
  logic                need_shift;
  logic                fin;
  rmph_pkg::rmph_out_t fin_res;

  // Shared decode of the current step.
  always_comb begin
    is_holder  = holder_valid_q && (holder_q == item_q.thread_id);
    limit      = recursive_mode_i ? DepthW'(rmph_pkg::MaxNesting) : DepthW'(1);
    out_free   = !out_valid_q || !out_stall_i;
    exec_scan  = (item_q.operation == rmph_pkg::OpRelease) && is_holder &&
                 (depth_q == DepthW'(1)) && (count_q != '0);
    take_cur   = (rd_idx_q == '0) || (ram_rdata_i.pri > best_pri_q);
    best_idx_d = take_cur ? rd_idx_q : best_idx_q;
    best_pri_d = take_cur ? ram_rdata_i.pri : best_pri_q;
    best_id_d  = take_cur ? ram_rdata_i.id : best_id_q;
    last_rd    = (CntW'(rd_idx_q) + CntW'(1)) >= count_q;
    after_best = CntW'(best_idx_d) + CntW'(1);
    need_shift = after_best < count_q;
    fin        = 1'b0;
    case (state_q)
      rmph_pkg::StExec:  fin = !exec_scan;
      rmph_pkg::StScan:  fin = last_rd && !need_shift;
      rmph_pkg::StShift: fin = last_rd;
      default:           fin = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmph_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = rmph_pkg::StExec;
        end
      end
      rmph_pkg::StExec: begin
        if (exec_scan) begin
          state_d = rmph_pkg::StScan;
        end
      end
      rmph_pkg::StScan: begin
        if (last_rd && need_shift) begin
          state_d = rmph_pkg::StShift;
        end
      end
      rmph_pkg::StShift: state_d = rmph_pkg::StShift;
      rmph_pkg::StDrain: begin
        if (out_free) begin
          state_d = rmph_pkg::StIdle;
        end
      end
      default: state_d = rmph_pkg::StIdle;
    endcase
    if (fin) begin
      state_d = out_free ? rmph_pkg::StIdle : rmph_pkg::StDrain;
    end
  end

  // Datapath, table accesses and result formation.
  always_comb begin
    item_d         = item_q;
    holder_valid_d = holder_valid_q;
    holder_d       = holder_q;
    depth_d        = depth_q;
    count_d        = count_q;
    rd_idx_d       = rd_idx_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;
    ram_req_o      = '0;
    fin_res        = '0;
    fin_res.status = rmph_pkg::StatOk;

    case (state_q)
      rmph_pkg::StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
        end
      end

      rmph_pkg::StExec: begin
        if (item_q.operation == rmph_pkg::OpAcquire) begin
          if (is_holder) begin
            fin_res.granted = 1'b1;
            if (depth_q < limit) begin
              depth_d = depth_q + DepthW'(1);
            end else begin
              depth_d        = limit;
              fin_res.status = rmph_pkg::StatOverflow;
            end
          end else if (!holder_valid_q) begin
            holder_valid_d  = 1'b1;
            holder_d        = item_q.thread_id;
            depth_d         = DepthW'(1);
            fin_res.granted = 1'b1;
          end else if (count_q < CntW'(rmph_pkg::MaxWaiters)) begin
            ram_req_o.we        = 1'b1;
            ram_req_o.waddr     = count_q[IdxW-1:0];
            ram_req_o.wdata.id  = item_q.thread_id;
            ram_req_o.wdata.pri = rmph_pkg::sat_pri(item_q.req_prio);
            count_d             = count_q + CntW'(1);
            fin_res.waiting     = 1'b1;
          end else begin
            fin_res.status = rmph_pkg::StatFull;
          end
        end else begin
          if (!is_holder) begin
            fin_res.status = rmph_pkg::StatNotHolder;
          end else if (depth_q > DepthW'(1)) begin
            depth_d = depth_q - DepthW'(1);
          end else if (count_q != '0) begin
            // Start the priority scan at the oldest waiter.
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = '0;
            rd_idx_d        = '0;
          end else begin
            holder_valid_d = 1'b0;
            holder_d       = '0;
            depth_d        = '0;
          end
        end
      end

      rmph_pkg::StScan: begin
        if (!last_rd) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = rd_idx_q + IdxW'(1);
          rd_idx_d        = rd_idx_q + IdxW'(1);
        end else if (need_shift) begin
          // Close the gap left by the chosen waiter.
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = after_best[IdxW-1:0];
          rd_idx_d        = after_best[IdxW-1:0];
        end else begin
          count_d               = count_q - CntW'(1);
          holder_d              = best_id_d;
          depth_d               = DepthW'(1);
          fin_res.handoff_valid = 1'b1;
          fin_res.new_holder    = best_id_d;
        end
      end

      rmph_pkg::StShift: begin
        // Read and write addresses always differ, so no forwarding is needed.
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = rd_idx_q - IdxW'(1);
        ram_req_o.wdata = ram_rdata_i;
        if (!last_rd) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = rd_idx_q + IdxW'(1);
          rd_idx_d        = rd_idx_q + IdxW'(1);
        end else begin
          count_d               = count_q - CntW'(1);
          holder_d              = best_id_q;
          depth_d               = DepthW'(1);
          fin_res.handoff_valid = 1'b1;
          fin_res.new_holder    = best_id_q;
        end
      end

      rmph_pkg::StDrain: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end

      default: ;
    endcase

    // Completed item goes to the output register, or parks until it frees.
    if (fin) begin
      if (out_free) begin
        out_d       = fin_res;
        out_valid_d = 1'b1;
      end else begin
        res_d = fin_res;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rmph_pkg::StIdle;
      holder_valid_q <= 1'b0;
      holder_q       <= '0;
      depth_q        <= '0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      holder_valid_q <= holder_valid_d;
      holder_q       <= holder_d;
      depth_q        <= depth_d;
      count_q        <= count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rd_idx_q <= rd_idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (state_q == rmph_pkg::StScan) begin
      best_idx_q <= best_idx_d;
      best_pri_q <= best_pri_d;
      best_id_q  <= best_id_d;
    end
  end

  assign in_stall_o  = (state_q != rmph_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/rmph_checker.sv
// ----------------------------------------------------------------------------
// rmph_checker
// Port-level assertions for the recursive mutex block, bound to the top level.
// ----------------------------------------------------------------------------
`include "recursive_mutex_priority_handoff_defines.svh"

module rmph_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rmph_pkg::rmph_out_t out_data_o
);

  // A stalled result beat must be held unchanged.
  `RMPH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // Only one request is in flight: an accepted beat closes the input.
  `RMPH_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request accepted while another was in progress")

  // A handoff only comes from a clean release.
  `RMPH_ASSERT_IMPL(a_handoff_clean, clk_i, rst_ni, out_valid_o && out_data_o.handoff_valid, (out_data_o.status == rmph_pkg::StatOk) && !out_data_o.granted && !out_data_o.waiting, "handoff beat carries acquire flags or an error")

  // Without a handoff no new holder is reported.
  `RMPH_ASSERT_IMPL(a_holder_zero, clk_i, rst_ni, out_valid_o && !out_data_o.handoff_valid, out_data_o.new_holder == '0, "new holder set without a handoff")

endmodule

bind recursive_mutex_priority_handoff rmph_checker u_rmph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
